// File: sv/hsl_to_rgb_converter_core_defines.svh
// assertion macros for the hsl to rgb converter core
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define HSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl2rgb same-cycle check failed");

// antecedent implies consequent in the next cycle
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsl2rgb next-cycle check failed");

`else

`define HSL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/hsl2rgb_pkg.sv
// shared constants and types for the hsl to rgb converter
package hsl2rgb_pkg;

  // hue resolution in bits, one turn is 2^HUE_BITS
  localparam int HUE_BITS = 16;

  // q1.15 register format
  localparam int REG_W   = 16;
  localparam int FRAC_W  = 15;
  localparam int ONE_Q   = 1 << FRAC_W;
  localparam int HALF_Q  = ONE_Q / 2;

  // derived datapath widths
  localparam int U_W     = HUE_BITS + 3;          // six times hue
  localparam int T_W     = HUE_BITS + 1;          // ramp factor 0..unit
  localparam int Q30_W   = 2 * FRAC_W + 1;        // p, q and q-p in q30
  localparam int LS_W    = 2 * REG_W;             // l*s product
  localparam int V_W     = 2 * FRAC_W + 1 + HUE_BITS; // channel value scaled
  localparam int BYTE_LO = 2 * FRAC_W + HUE_BITS; // lsb of the output byte

  // hue scale points
  localparam logic [U_W-1:0] UNIT_U  = U_W'(1) << HUE_BITS;
  localparam logic [U_W-1:0] TURN_U  = U_W'(6) << HUE_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = REG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SATURATION = CFG_IDX_W'(0),
    REG_LIGHTNESS  = CFG_IDX_W'(1)
  } cfg_reg_t;

  localparam logic [REG_W-1:0] SAT_RESET   = REG_W'(32768);
  localparam logic [REG_W-1:0] LIGHT_RESET = REG_W'(6554);

  // stream widths
  localparam int IN_DATA_W  = ((HUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 24;

  // number of register stages
  localparam int NST = 5;

  typedef logic [U_W-1:0] hue6_t;
  typedef logic [T_W-1:0] ramp_t;

endpackage

// File: sv/hsl_to_rgb_converter_core.sv
// hsl to rgb converter: five-stage pipeline, one hue in, one rgb out per cycle unless stalled
// each accepted hue moves through stages one to five in order, out_tvalid is stage five valid
// throughput: one transaction per cycle when out_tready is high, via the per-stage handshake
// the d*t multiply (31 x 17 bits) sits alone in stage three, the *255 in stage five
// reset: rst_n low synchronously empties all stages, saturation goes to 1.0, lightness to 0.2
`include "hsl_to_rgb_converter_core_defines.svh"

module hsl_to_rgb_converter_core import hsl2rgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // hue stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [HUE_BITS-1:0] hue, rest zero fill
  // color stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  // configuration registers
  logic [REG_W-1:0] sat_r;
  logic [REG_W-1:0] light_r;

  // pipeline valid bits and per-stage ready
  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  // stage 1
  hue6_t           u_r   [3];
  logic [REG_W-1:0] s1_s_r;
  logic [REG_W-1:0] s1_l_r;
  logic [LS_W-1:0]  s1_ls_r;
  // stage 2
  ramp_t            t_r   [3];
  logic [Q30_W-1:0] s2_p_r;
  logic [Q30_W-1:0] s2_d_r;
  // stage 3
  logic [V_W-1:0]   prod_r [3];
  logic [Q30_W-1:0] s3_p_r;
  // stage 4
  logic [V_W-1:0]   v_r   [3];
  // stage 5
  logic [7:0]       byte_r [3];

  // combinational next values
  hue6_t            u_nxt  [3];
  ramp_t            t_nxt  [3];
  logic [REG_W-1:0] s_clamp_nxt;
  logic [REG_W-1:0] l_clamp_nxt;
  logic [Q30_W-1:0] p_nxt;
  logic [Q30_W-1:0] d_nxt;
  logic [7:0]       byte_nxt [3];

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r   <= SAT_RESET;
      light_r <= LIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SATURATION: sat_r   <= cfg_data;
        REG_LIGHTNESS:  light_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ready ripples back from the output, a stage takes data when empty or draining
  always_comb begin
    rdy[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: six times hue, channel offsets of one and two thirds, clamp registers, l*s product
  always_comb begin
    logic [U_W-1:0] h;
    logic [U_W:0]   sum_red;
    logic [U_W:0]   sum_blue;
    h = U_W'(in_tdata[HUE_BITS-1:0]);
    u_nxt[1] = (h << 2) + (h << 1);
    sum_red  = {1'b0, u_nxt[1]} + {1'b0, UNIT_U << 1};
    sum_blue = {1'b0, u_nxt[1]} + {1'b0, UNIT_U << 2};
    u_nxt[0] = (sum_red >= {1'b0, TURN_U}) ? U_W'(sum_red - {1'b0, TURN_U}) : U_W'(sum_red);
    u_nxt[2] = (sum_blue >= {1'b0, TURN_U}) ? U_W'(sum_blue - {1'b0, TURN_U})
                                            : U_W'(sum_blue);
    s_clamp_nxt = (sat_r > REG_W'(ONE_Q)) ? REG_W'(ONE_Q) : sat_r;
    l_clamp_nxt = (light_r > REG_W'(ONE_Q)) ? REG_W'(ONE_Q) : light_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int c = 0; c < 3; c++) begin
        u_r[c] <= u_nxt[c];
      end
      s1_s_r  <= s_clamp_nxt;
      s1_l_r  <= l_clamp_nxt;
      s1_ls_r <= LS_W'(s_clamp_nxt) * LS_W'(l_clamp_nxt);
    end
  end

  // stage 2: p and q-p from l and s, ramp factor per channel
  always_comb begin
    logic [Q30_W+1:0] l15;
    logic [Q30_W+1:0] s15;
    logic [Q30_W+1:0] ls;
    l15 = (Q30_W+2)'(s1_l_r) << FRAC_W;
    s15 = (Q30_W+2)'(s1_s_r) << FRAC_W;
    ls  = (Q30_W+2)'(s1_ls_r);
    if (s1_l_r < REG_W'(HALF_Q)) begin
      p_nxt = Q30_W'(l15 - ls);
      d_nxt = Q30_W'(ls << 1);
    end else begin
      p_nxt = Q30_W'(l15 - s15 + ls);
      d_nxt = Q30_W'((s15 - ls) << 1);
    end
    // rising below one sixth, flat top to one half, falling to two thirds, else floor
    for (int c = 0; c < 3; c++) begin
      if (u_r[c] < UNIT_U) begin
        t_nxt[c] = T_W'(u_r[c]);
      end else if (u_r[c] < UNIT_U * U_W'(3)) begin
        t_nxt[c] = T_W'(UNIT_U);
      end else if (u_r[c] < (UNIT_U << 2)) begin
        t_nxt[c] = T_W'((UNIT_U << 2) - u_r[c]);
      end else begin
        t_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int c = 0; c < 3; c++) begin
        t_r[c] <= t_nxt[c];
      end
      s2_p_r <= p_nxt;
      s2_d_r <= d_nxt;
    end
  end

  // stage 3: (q-p) times ramp factor
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= V_W'((Q30_W+T_W)'(s2_d_r) * (Q30_W+T_W)'(t_r[c]));
      end
      s3_p_r <= s2_p_r;
    end
  end

  // stage 4: add floor level p scaled by one unit
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int c = 0; c < 3; c++) begin
        v_r[c] <= (V_W'(s3_p_r) << HUE_BITS) + prod_r[c];
      end
    end
  end

  // stage 5: value times 255, keep the integer byte
  always_comb begin
    logic [V_W+7:0] scaled;
    for (int c = 0; c < 3; c++) begin
      scaled      = ((V_W+8)'(v_r[c]) << 8) - (V_W+8)'(v_r[c]);
      byte_nxt[c] = scaled[BYTE_LO+7:BYTE_LO];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < 3; c++) begin
        byte_r[c] <= byte_nxt[c];
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {byte_r[2], byte_r[1], byte_r[0]};

  // checks
  `HSL_ASSERT_NEXT(a_accept_fills_stage1, clk, rst_n, in_tvalid && in_tready, vld_r[0])
  `HSL_ASSERT_SAME(a_empty_out_takes_input, clk, rst_n, !out_tvalid, in_tready)
  `HSL_ASSERT_SAME(a_ramp_red_bound, clk, rst_n, vld_r[1], t_r[0] <= T_W'(UNIT_U))
  `HSL_ASSERT_SAME(a_ramp_blue_bound, clk, rst_n, vld_r[1], t_r[2] <= T_W'(UNIT_U))

endmodule

// File: tb/hsl_to_rgb_converter_checker.sv
// checker for the hsl to rgb converter: tracks registers, predicts colors, compares results
module hsl_to_rgb_converter_checker import hsl2rgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    colors_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  localparam logic [63:0] HUE_UNIT = 64'(1) << HUE_BITS;
  localparam logic [63:0] HUE_TURN = 64'(6) << HUE_BITS;

  logic [REG_W-1:0] sat_shadow;
  logic [REG_W-1:0] light_shadow;
  rgb_t             color_q[$];

  // channel level along the hue ramp, q30 scaled by HUE_UNIT
  function automatic logic [63:0] ramp_level(logic [63:0] p30, logic [63:0] q30,
                                             logic [63:0] u);
    logic [63:0] d;
    d = q30 - p30;
    if (u < HUE_UNIT) return p30 * HUE_UNIT + d * u;
    if (u < 3 * HUE_UNIT) return q30 * HUE_UNIT;
    if (u < 4 * HUE_UNIT) return p30 * HUE_UNIT + d * (4 * HUE_UNIT - u);
    return p30 * HUE_UNIT;
  endfunction

  // scale by 255 and truncate to a byte, saturating at 255
  function automatic logic [7:0] level_byte(logic [63:0] v);
    logic [63:0] b;
    b = (v * 255) >> (2 * FRAC_W + HUE_BITS);
    return (b > 255) ? 8'hFF : b[7:0];
  endfunction

  // expected color for one hue under the current saturation and lightness
  function automatic rgb_t hsl_color(logic [HUE_BITS-1:0] hue, logic [REG_W-1:0] sat_reg,
                                     logic [REG_W-1:0] light_reg);
    logic [63:0] s, l, q30, p30, u;
    rgb_t c;
    s = (sat_reg > ONE_Q) ? 64'(ONE_Q) : 64'(sat_reg);
    l = (light_reg > ONE_Q) ? 64'(ONE_Q) : 64'(light_reg);
    if (s == 0) begin
      // gray: all channels from lightness alone
      c.red = level_byte((l << FRAC_W) << HUE_BITS);
      c.green = c.red;
      c.blue = c.red;
      return c;
    end
    if (l < HALF_Q) q30 = l * (ONE_Q + s);
    else q30 = l * ONE_Q + s * ONE_Q - l * s;
    p30 = 2 * l * ONE_Q - q30;
    u = 6 * 64'(hue);
    c.red = level_byte(ramp_level(p30, q30, (u + 2 * HUE_UNIT) % HUE_TURN));
    c.green = level_byte(ramp_level(p30, q30, u));
    c.blue = level_byte(ramp_level(p30, q30, (u + 4 * HUE_UNIT) % HUE_TURN));
    return c;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    rgb_t seen;
    rgb_t want;
    if (!rst_n) begin
      sat_shadow <= SAT_RESET;
      light_shadow <= LIGHT_RESET;
      color_q.delete();
      mismatches <= 0;
      colors_pending <= 0;
    end else begin
      // register writes, spare indexes are ignored
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SATURATION) sat_shadow <= cfg_data;
        else if (cfg_index == REG_LIGHTNESS) light_shadow <= cfg_data;
      end
      // result transaction against the oldest expected color
      if (out_tvalid && out_tready) begin
        seen = rgb_t'(out_tdata);
        if (color_q.size() == 0) begin
          $display("%0t: unexpected color, expected none actual %06h", $time, out_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = color_q.pop_front();
          if (seen.red !== want.red)
            $display("%0t: red expected %0d actual %0d", $time, want.red, seen.red);
          if (seen.green !== want.green)
            $display("%0t: green expected %0d actual %0d", $time, want.green, seen.green);
          if (seen.blue !== want.blue)
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, seen.blue);
          if (seen !== want) mismatches <= mismatches + 1;
        end
      end
      // hue transaction
      if (in_tvalid && in_tready)
        color_q.push_back(hsl_color(in_tdata[HUE_BITS-1:0], sat_shadow, light_shadow));
      colors_pending <= color_q.size();
    end
  end

endmodule

// File: tb/hsl_to_rgb_converter_core_test.sv
// testbench top for the hsl to rgb converter: stimulus, flow control and verdict
module hsl_to_rgb_converter_core_test;
  import hsl2rgb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_HUES  = 65;
  localparam int IDLE_PCT    = 27;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [HUE_BITS-1:0] hue, rest zero fill
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] red, [15:8] green, [23:16] blue

  int   mismatches;
  int   colors_pending;
  int   cycle_count;
  int   hold_left;
  logic gaps_on;
  logic hold_req;
  logic hold_done;

  hsl_to_rgb_converter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hsl_to_rgb_converter_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatches     (mismatches),
    .colors_pending (colors_pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // color receiver: random stalls plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
  end
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // one register write transaction, starting and ending at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one hue, with random gaps ahead of it
  task automatic send_hue(input logic [HUE_BITS-1:0] hue);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'(hue);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and let every expected color drain
  task automatic drain_colors();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (colors_pending != 0);
  endtask

  // new saturation and lightness, plus a write to a spare index
  task automatic set_color_regs(input logic [REG_W-1:0] sat, input logic [REG_W-1:0] light);
    write_reg(REG_SATURATION, sat);
    write_reg(REG_LIGHTNESS, light);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_LIGHTNESS) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
  endtask

  logic [HUE_BITS-1:0] edge_hues[16] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h2AAA, 16'h2AAB, 16'h5555, 16'h5556, 16'h7FFF,
    16'h8000, 16'hAAAA, 16'hAAAB, 16'hD555, 16'hD556, 16'h1555, 16'h4000, 16'hC000
  };

  initial begin
    logic [REG_W-1:0] sat_set[8];
    logic [REG_W-1:0] light_set[8];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // hue ramp corners and wrap points under the reset registers
    foreach (edge_hues[i]) send_hue(edge_hues[i]);
    drain_colors();

    // register settings: gray x2, full, above 1, black, below half, at half, random
    sat_set = '{16'd0, 16'd0, 16'd32768, 16'hFFFF, 16'd32768, 16'd0, 16'd0, 16'd0};
    light_set = '{16'd0, 16'd32768, 16'd32768, 16'hFFFF, 16'd0, 16'd16383, 16'd16384, 16'd0};
    sat_set[0] = REG_W'($urandom);
    sat_set[0] = 16'd0;
    light_set[0] = REG_W'($urandom_range(0, ONE_Q));
    sat_set[5] = REG_W'($urandom);
    sat_set[6] = REG_W'($urandom_range(1, ONE_Q));
    sat_set[7] = REG_W'($urandom_range(0, ONE_Q));
    light_set[7] = REG_W'($urandom_range(0, ONE_Q));

    for (int ph = 0; ph < 8; ph++) begin
      set_color_regs(sat_set[ph], light_set[ph]);
      // one phase runs both sides with no gaps at all
      gaps_on = (ph != 2);
      for (int n = 0; n < PHASE_HUES; n++) begin
        // long receiver hold-off while hues keep coming
        if (ph == 4 && n == 10) hold_req <= 1'b1;
        send_hue(HUE_BITS'($urandom));
      end
      drain_colors();
      gaps_on = 1'b1;
    end

    // a last phase with fully random register contents
    set_color_regs(REG_W'($urandom), REG_W'($urandom));
    for (int n = 0; n < PHASE_HUES; n++) send_hue(HUE_BITS'($urandom));
    drain_colors();

    repeat (NST + 5) @(negedge clk);
    if (mismatches == 0 && colors_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
